>>> hw/rtl/wsfd_pkg.sv
package wsfd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASKKEY = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    localparam logic [7:0] MASK_FLAG = 8'h80;
    localparam logic [6:0] LEN_FIELD = 7'h7F;
    localparam logic [6:0] LEN_16    = 7'd126;
    localparam logic [6:0] LEN_64    = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [2:0] KEY_BYTES   = 3'd4;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       frame_end;
    } t_res;

endpackage

>>> hw/rtl/wsfd_if.sv
interface wsfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface wsfd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       frame_end;

    modport source (output valid, output payload_byte, output frame_end, input ready);
    modport sink   (input valid, input payload_byte, input frame_end, output ready);
endinterface

>>> hw/rtl/wsfd_in_stage.sv
module wsfd_in_stage
    import wsfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    wsfd_in_if.sink     i_in,
    input  logic        i_take,
    output logic        o_valid,
    output logic [7:0]  o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign i_in.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_byte     = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.in_byte;
        end
    end

endmodule

>>> hw/rtl/wsfd_parser.sv
module wsfd_parser
    import wsfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_byte,
    input  logic        i_out_free,
    output logic        o_take,
    output logic        o_res_valid,
    output t_res        o_res
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_ext_left, n_ext_left;
    logic        r_masked, n_masked;
    logic [63:0] r_remaining, n_remaining;
    logic [31:0] r_key, n_key;
    logic [2:0]  r_key_left, n_key_left;
    logic [1:0]  r_pos, n_pos;

    logic        emits;
    logic        last;
    logic [6:0]  len;
    logic [1:0]  key_idx;
    logic [7:0]  key_byte;

    assign emits       = (r_phase == PH_PAYLOAD);
    assign o_take      = i_valid && (!emits || i_out_free);
    assign o_res_valid = o_take && emits;
    assign len         = i_byte[6:0] & LEN_FIELD;
    // remaining is never zero in the payload phase, so one left means last
    assign last        = (r_remaining <= 64'd1);
    assign key_idx     = 2'd3 - r_pos;
    assign key_byte    = r_key[{key_idx, 3'b000} +: 8];

    assign o_res.payload_byte = r_masked ? (i_byte ^ key_byte) : i_byte;
    assign o_res.frame_end    = last;

    always_comb begin
        n_phase     = r_phase;
        n_ext_left  = r_ext_left;
        n_masked    = r_masked;
        n_remaining = r_remaining;
        n_key       = r_key;
        n_key_left  = r_key_left;
        n_pos       = r_pos;
        case (r_phase)
            PH_HDR1: begin
                n_masked = (i_byte & MASK_FLAG) != 8'h00;
                if (len == LEN_16 || len == LEN_64) begin
                    n_remaining = '0;
                    n_ext_left  = (len == LEN_16) ? EXT16_BYTES : EXT64_BYTES;
                    n_phase     = PH_EXTLEN;
                end else begin
                    n_remaining = {57'd0, len};
                    if (n_masked) begin
                        n_key      = '0;
                        n_key_left = KEY_BYTES;
                        n_phase    = PH_MASKKEY;
                    end else begin
                        n_pos   = 2'd0;
                        n_phase = (len == 7'd0) ? PH_HDR0 : PH_PAYLOAD;
                    end
                end
            end
            PH_EXTLEN: begin
                n_remaining = {r_remaining[55:0], i_byte};
                if (r_ext_left != 4'd0) begin
                    n_ext_left = r_ext_left - 4'd1;
                end
                if (n_ext_left == 4'd0) begin
                    if (r_masked) begin
                        n_key      = '0;
                        n_key_left = KEY_BYTES;
                        n_phase    = PH_MASKKEY;
                    end else begin
                        n_pos   = 2'd0;
                        n_phase = (n_remaining == '0) ? PH_HDR0 : PH_PAYLOAD;
                    end
                end
            end
            PH_MASKKEY: begin
                n_key = {r_key[23:0], i_byte};
                if (r_key_left != 3'd0) begin
                    n_key_left = r_key_left - 3'd1;
                end
                if (n_key_left == 3'd0) begin
                    n_pos   = 2'd0;
                    n_phase = (r_remaining == '0) ? PH_HDR0 : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (r_remaining != '0) begin
                    n_remaining = r_remaining - 64'd1;
                end
                n_pos = r_pos + 2'd1;
                if (last) begin
                    n_pos   = 2'd0;
                    n_phase = PH_HDR0;
                end
            end
            default: begin
                n_phase = PH_HDR1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR0;
            r_ext_left  <= '0;
            r_masked    <= 1'b0;
            r_remaining <= '0;
            r_key       <= '0;
            r_key_left  <= '0;
            r_pos       <= '0;
        end else if (o_take) begin
            r_phase     <= n_phase;
            r_ext_left  <= n_ext_left;
            r_masked    <= n_masked;
            r_remaining <= n_remaining;
            r_key       <= n_key;
            r_key_left  <= n_key_left;
            r_pos       <= n_pos;
        end
    end

    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_remaining != '0)
        else $error("payload phase with nothing left to emit");

    a_result_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_out_free)
        else $error("result produced with output register full");

    a_end_returns_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.frame_end |=> r_phase == PH_HDR0)
        else $error("frame end did not return to header parsing");

    a_extlen_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_EXTLEN |-> r_ext_left != 4'd0)
        else $error("extended length phase with no bytes left");

endmodule

>>> hw/rtl/wsfd_out_stage.sv
module wsfd_out_stage
    import wsfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_res        i_res,
    output logic        o_free,
    wsfd_out_if.source  o_out
);

    logic r_valid;
    t_res r_res;

    assign o_free             = !r_valid || o_out.ready;
    assign o_out.valid        = r_valid;
    assign o_out.payload_byte = r_res.payload_byte;
    assign o_out.frame_end    = r_res.frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // hold the beat until the sink takes it
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

>>> hw/rtl/websocket_frame_decoder.sv
// WebSocket frame decoder.
// Input channel i_in carries one received byte per beat (in_byte). Output
// channel o_out carries one unmasked payload byte per beat, with frame_end
// set on the last payload byte of each frame. Header bytes, extended length
// bytes and masking key bytes produce no output beat; zero-length frames
// produce nothing.
// Each accepted byte is held in an input register, parsed against the frame
// state and its payload byte written to the output register. One byte is
// taken every cycle while the output register is free; the 64-bit
// length decrement and compare sit in the single parse step between
// the two registers.
// Reset (synchronous, active low) empties both registers and returns the
// parser to expecting the first header byte of a frame.
// When the receiver stalls, the output beat is held; the parser keeps
// consuming header, length and key bytes, and the input register fills,
// after which i_in ready drops until the output register drains.
module websocket_frame_decoder
    import wsfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    wsfd_in_if.sink     i_in,
    wsfd_out_if.source  o_out
);

    logic       stg_valid;
    logic [7:0] stg_byte;
    logic       take;
    logic       res_valid;
    logic       out_free;
    t_res       res;

    wsfd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (stg_valid),
        .o_byte  (stg_byte)
    );

    wsfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stg_valid),
        .i_byte      (stg_byte),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wsfd_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_out   (o_out)
    );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import wsfd_pkg::*;

    typedef enum int {
        ENC_SHORT,
        ENC_EXT16,
        ENC_EXT64
    } t_len_enc;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 200;

    // Mirrors the deframer: parse state plus the payload bytes still owed.
    class ws_deframe_board;
        t_phase      phase;
        logic [3:0]  ext_left;
        logic        masked;
        logic [63:0] remaining;
        logic [31:0] key;
        logic [2:0]  key_left;
        logic [1:0]  key_pos;
        t_res        expected_bytes[$];
        int          errors;

        function new();
            phase     = PH_HDR0;
            ext_left  = '0;
            masked    = 1'b0;
            remaining = '0;
            key       = '0;
            key_left  = '0;
            key_pos   = '0;
            errors    = 0;
        endfunction

        function void start_payload();
            key_pos = '0;
            phase   = (remaining == 64'd0) ? PH_HDR0 : PH_PAYLOAD;
        endfunction

        function void length_done();
            if (masked) begin
                key      = '0;
                key_left = KEY_BYTES;
                phase    = PH_MASKKEY;
            end else begin
                start_payload();
            end
        endfunction

        function void note_rx_byte(logic [7:0] b);
            logic [6:0] len7;
            t_res       r;
            case (phase)
                PH_HDR1: begin
                    len7   = b[6:0] & LEN_FIELD;
                    masked = ((b & MASK_FLAG) != 8'd0);
                    if (len7 == LEN_16) begin
                        remaining = '0;
                        ext_left  = EXT16_BYTES;
                        phase     = PH_EXTLEN;
                    end else if (len7 == LEN_64) begin
                        remaining = '0;
                        ext_left  = EXT64_BYTES;
                        phase     = PH_EXTLEN;
                    end else begin
                        remaining = {57'd0, len7};
                        length_done();
                    end
                end
                PH_EXTLEN: begin
                    remaining = {remaining[55:0], b};
                    if (ext_left != 4'd0) ext_left = ext_left - 4'd1;
                    if (ext_left == 4'd0) length_done();
                end
                PH_MASKKEY: begin
                    key = {key[23:0], b};
                    if (key_left != 3'd0) key_left = key_left - 3'd1;
                    if (key_left == 3'd0) start_payload();
                end
                PH_PAYLOAD: begin
                    r.payload_byte = masked ? (b ^ key[8 * (3 - int'(key_pos)) +: 8]) : b;
                    if (remaining != 64'd0) remaining = remaining - 64'd1;
                    key_pos     = key_pos + 2'd1;
                    r.frame_end = (remaining == 64'd0);
                    expected_bytes = {expected_bytes, r};
                    if (remaining == 64'd0) begin
                        key_pos = '0;
                        phase   = PH_HDR0;
                    end
                end
                default: phase = PH_HDR1;
            endcase
        endfunction

        function void check_payload_beat(logic [7:0] pb, logic fe);
            t_res want;
            if (expected_bytes.size() == 0) begin
                errors++;
                $display("%0t: beat with nothing expected: payload_byte %02h frame_end %0b",
                         $time, pb, fe);
                return;
            end
            want = expected_bytes.pop_front();
            if (pb !== want.payload_byte) begin
                errors++;
                $display("%0t: payload_byte expected %02h actual %02h",
                         $time, want.payload_byte, pb);
            end
            if (fe !== want.frame_end) begin
                errors++;
                $display("%0t: frame_end expected %0b actual %0b",
                         $time, want.frame_end, fe);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    wsfd_in_if  in_ch ();
    wsfd_out_if out_ch ();

    websocket_frame_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    ws_deframe_board board;
    int  in_idle_pct  = 9;
    int  out_idle_pct = 9;
    bit  hold_req     = 1'b0;
    int  bytes_sent   = 0;
    int  stall_cycles = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offer one byte, possibly after first dropping valid; return once it is taken.
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < in_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        board.note_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] hdr0, input logic masked, input t_len_enc enc,
                              input logic [63:0] len, input logic [31:0] key, input int nbytes);
        logic [6:0] code;
        case (enc)
            ENC_EXT16: code = LEN_16;
            ENC_EXT64: code = LEN_64;
            default:   code = len[6:0];
        endcase
        send_byte(hdr0);
        send_byte({masked, code});
        if (enc == ENC_EXT16) begin
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end else if (enc == ENC_EXT64) begin
            for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
        end
        if (masked) begin
            for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
        end
        for (int i = 0; i < nbytes; i++) send_byte(pick_byte());
    endtask

    task automatic send_random_frame();
        t_len_enc    enc;
        logic [63:0] len;
        int          sel;
        sel = $urandom_range(0, 99);
        enc = (sel < 70) ? ENC_SHORT : (sel < 85) ? ENC_EXT16 : ENC_EXT64;
        if ($urandom_range(0, 9) == 0)
            len = (enc == ENC_SHORT) ? 64'd125 : 64'($urandom_range(0, 300));
        else if (enc == ENC_SHORT && $urandom_range(0, 9) == 0)
            len = 64'($urandom_range(0, 125));
        else
            len = 64'($urandom_range(0, 12));
        send_frame(pick_byte(), 1'($urandom), enc, len, $urandom, int'(len));
    endtask

    // Random bytes from a frame boundary, then pad until the parser is back at one.
    // Keep any length picked up here short so the pad stays bounded.
    task automatic send_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 6)) begin
            b = 8'($urandom);
            if (board.phase == PH_HDR1 && b[6:0] >= LEN_16)
                b[6:0] = 7'($urandom_range(0, 125));
            send_byte(b);
        end
        while (board.phase != PH_HDR0) send_byte(pick_byte());
    endtask

    // Receiver: take beats, stall at random, and hold off on request.
    initial begin
        int hold_left;
        hold_left    = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                board.check_payload_beat(out_ch.payload_byte, out_ch.frame_end);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req     = 1'b0;
                hold_left    = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("websocket_frame_decoder: mismatch");
                $finish;
            end
        end
    end

    initial begin
        bit held, paused;
        held   = 1'b0;
        paused = 1'b0;
        board  = new();
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= 8'h00;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero-length frames in every encoding, extreme keys and headers,
        // non-minimal extended lengths, masked and unmasked payloads.
        send_frame(8'h00, 1'b0, ENC_SHORT, 64'd0, 32'h0000_0000, 0);
        send_frame(8'hFF, 1'b1, ENC_SHORT, 64'd0, 32'hFFFF_FFFF, 0);
        send_frame(8'h81, 1'b0, ENC_SHORT, 64'd3, 32'h0000_0000, 3);
        send_frame(8'h82, 1'b1, ENC_SHORT, 64'd5, 32'hA5C3_0FF0, 5);
        send_frame(8'h89, 1'b1, ENC_SHORT, 64'd1, 32'hFFFF_FFFF, 1);
        send_frame(8'h01, 1'b0, ENC_EXT16, 64'd0, 32'h0000_0000, 0);
        send_frame(8'h02, 1'b1, ENC_EXT16, 64'd5, 32'h1234_5678, 5);
        send_frame(8'h88, 1'b1, ENC_EXT64, 64'd0, 32'h0000_0000, 0);
        send_frame(8'h8A, 1'b0, ENC_EXT64, 64'd3, 32'h0000_0000, 3);

        while (bytes_sent < 900) begin
            if (!held && bytes_sent >= 300) begin
                // Stall the receiver across a long frame so the input backs up.
                held     = 1'b1;
                hold_req = 1'b1;
                send_frame(8'h82, 1'($urandom), ENC_EXT16, 64'd400, $urandom, 400);
            end else if (!paused && bytes_sent >= 650) begin
                paused = 1'b1;
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (board.expected_bytes.size() != 0) @(posedge i_clk);
            end else if ($urandom_range(0, 99) < 85) begin
                send_random_frame();
            end else begin
                send_noise();
            end
            if (bytes_sent >= 750 && bytes_sent < 880) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end else begin
                in_idle_pct  = 9;
                out_idle_pct = 9;
            end
        end

        // A length with the top bit set; the frame is never finished.
        send_frame(8'h82, 1'b1, ENC_EXT64, 64'h8000_0000_0000_0005, $urandom, 24);

        in_ch.valid <= 1'b0;
        while (board.expected_bytes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.expected_bytes.size() == 0)
            $display("websocket_frame_decoder: match");
        else
            $display("websocket_frame_decoder: mismatch");
        $finish;
    end

endmodule
